### rtl/rnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_pkg: shared types and constants for the radix number parser
// Value width, base codes, character codes and result record.
// ----------------------------------------------------------------------------
package rnp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int CH_WIDTH    = 8;
  localparam int RADIX_WIDTH = 5;

  localparam logic [RADIX_WIDTH-1:0] RADIX_8     = 5'd8;
  localparam logic [RADIX_WIDTH-1:0] RADIX_10    = 5'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_16    = 5'd16;

  // decoded base
  localparam logic [1:0] BASE_10 = 2'd0;
  localparam logic [1:0] BASE_8  = 2'd1;
  localparam logic [1:0] BASE_16 = 2'd2;

  localparam logic [CH_WIDTH-1:0] CH_0     = 8'h30;
  localparam logic [CH_WIDTH-1:0] CH_7     = 8'h37;
  localparam logic [CH_WIDTH-1:0] CH_8     = 8'h38;
  localparam logic [CH_WIDTH-1:0] CH_9     = 8'h39;
  localparam logic [CH_WIDTH-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_WIDTH-1:0] CH_LC_F  = 8'h66;
  localparam logic [CH_WIDTH-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_WIDTH-1:0] CH_UC_F  = 8'h46;
  localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } digit_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        consumed;
    logic                        done_res;
    logic                        error;
  } result_t;

  // sign-extend from the top value bit, then fit to the output width
  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = signed'(v);
    return OUT_WIDTH'(s);
  endfunction

endpackage
`default_nettype wire

### rtl/rnp_digit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_digit: character to digit decode
// Maps an ASCII character to its digit value in the current base.
// ----------------------------------------------------------------------------
module rnp_digit import rnp_pkg::*; (
  input  wire logic [CH_WIDTH-1:0] ch,
  input  wire logic                end_of_text,
  input  wire logic [1:0]          base,
  output digit_t                   digit
);

  logic is_low, is_89, is_lc, is_uc;

  always_comb begin
    is_low = (ch >= CH_0) && (ch <= CH_7);
    is_89  = (ch == CH_8) || (ch == CH_9);
    is_lc  = (ch >= CH_LC_A) && (ch <= CH_LC_F);
    is_uc  = (ch >= CH_UC_A) && (ch <= CH_UC_F);
    digit.valid = 1'b0;
    digit.val   = ch[3:0];
    if (!end_of_text) begin
      if (is_low) begin
        digit.valid = 1'b1;
      end else if (is_89) begin
        digit.valid = (base != BASE_8);
      end else if ((is_lc || is_uc) && (base == BASE_16)) begin
        // 'a'/'A' have low nibble 1
        digit.valid = 1'b1;
        digit.val   = ch[3:0] + 4'd9;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rnp_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_accum: number state and accumulate datapath
// Holds accumulator, sign and in-progress flag; forms one result per step.
// ----------------------------------------------------------------------------
module rnp_accum import rnp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [CH_WIDTH-1:0] ch,
  input  wire logic                first,
  input  wire logic                scan_mode,
  input  wire logic                end_of_text,
  input  wire logic [1:0]          base,
  input  wire digit_t              digit,
  output result_t                  result
);

  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   negative, negative_next;
  logic                   active, active_next;
  logic [VALUE_WIDTH-1:0] scaled, digit_ext, value_raw;
  logic                   is_sign;

  always_comb begin
    case (base)
      BASE_8:  scaled = acc << 3;
      BASE_16: scaled = acc << 4;
      default: scaled = (acc << 3) + (acc << 1);
    endcase
  end

  assign digit_ext = {{(VALUE_WIDTH-4){1'b0}}, digit.val};
  assign is_sign   = scan_mode && !end_of_text && ((ch == CH_PLUS) || (ch == CH_MINUS));

  always_comb begin
    acc_next        = acc;
    negative_next   = negative;
    active_next     = active;
    value_raw       = '0;
    result.consumed = 1'b0;
    result.done_res = 1'b0;
    result.error    = 1'b0;
    if (first) begin
      acc_next      = '0;
      negative_next = 1'b0;
      active_next   = 1'b1;
      if (digit.valid) begin
        acc_next        = digit_ext;
        value_raw       = digit_ext;
        result.consumed = 1'b1;
      end else if (is_sign) begin
        negative_next   = (ch == CH_MINUS);
        result.consumed = 1'b1;
      end else begin
        active_next     = 1'b0;
        result.done_res = 1'b1;
        result.error    = !scan_mode;
      end
    end else if (active) begin
      if (digit.valid) begin
        acc_next        = scaled + digit_ext;
        value_raw       = scaled + digit_ext;
        result.consumed = 1'b1;
      end else begin
        value_raw       = negative ? (VALUE_WIDTH'(0) - acc) : acc;
        result.done_res = 1'b1;
        active_next     = 1'b0;
      end
    end
    result.value = to_out(value_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      negative <= 1'b0;
      active   <= 1'b0;
    end else if (step) begin
      acc      <= acc_next;
      negative <= negative_next;
      active   <= active_next;
    end
  end

endmodule
`default_nettype wire

### rtl/radix_number_parser_core.sv
`default_nettype none
// Pipeline: an accepted request goes to the input register, then the result register;
//   one request per cycle sustained while out_stall is low, set by the single
//   shift-add accumulate step between the two registers.
// Reset (rst, synchronous): radix = 10, accumulator/sign/in-progress cleared,
//   both pipeline registers empty.
// ----------------------------------------------------------------------------
// radix_number_parser_core: ASCII radix integer parser, top level
// Input register, digit decode, accumulate, result register.
// ----------------------------------------------------------------------------
module radix_number_parser_core import rnp_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [RADIX_WIDTH-1:0]      cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [CH_WIDTH-1:0]         ch,
  input  wire logic                        first,
  input  wire logic                        scan_mode,
  input  wire logic                        end_of_text,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0]      value,
  output logic                             consumed,
  output logic                             done_res,
  output logic                             error
);

  logic [RADIX_WIDTH-1:0] radix;
  logic [1:0]             base;

  logic                   s1_valid;
  logic [CH_WIDTH-1:0]    s1_ch;
  logic                   s1_first, s1_scan, s1_eot;
  logic                   s2_load, step;
  digit_t                 digit;
  result_t                res;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_10;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  always_comb begin
    case (radix)
      RADIX_8:  base = BASE_8;
      RADIX_16: base = BASE_16;
      default:  base = BASE_10;
    endcase
  end

  assign s2_load  = !out_valid || !out_stall;
  assign step     = s1_valid && s2_load;
  assign in_stall = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch    <= ch;
      s1_first <= first;
      s1_scan  <= scan_mode;
      s1_eot   <= end_of_text;
    end
  end

  rnp_digit u_digit (
    .ch          (s1_ch),
    .end_of_text (s1_eot),
    .base        (base),
    .digit       (digit)
  );

  rnp_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ch          (s1_ch),
    .first       (s1_first),
    .scan_mode   (s1_scan),
    .end_of_text (s1_eot),
    .base        (base),
    .digit       (digit),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      value    <= res.value;
      consumed <= res.consumed;
      done_res <= res.done_res;
      error    <= res.error;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> done_res)
    else $error("error without end of number");

  a_take_or_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(consumed && done_res))
    else $error("character both taken and ending the number");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> (value == '0) && !consumed)
    else $error("error result carries data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted step lost in pipeline");
`endif

endmodule
`default_nettype wire
